[rtl/khtab_pkg.sv]
// Shared types, constants and the slot hash of the keyed counter hash table.
`default_nettype none
package khtab_pkg;

  localparam int SLOT_W      = 10;
  localparam int HASH_SLOTS  = 1 << SLOT_W;
  localparam int MAX_ENTRIES = 768;
  localparam int ENT_W       = 10;
  localparam int ENT_DEPTH   = MAX_ENTRIES + 1;
  localparam int CFG_IDX_W   = 2;

  localparam logic [63:0] ZERO_KEY_SUBST = 64'hfefff00dc00ffeee;

  localparam logic [2:0] KIND_ADD    = 3'd0;
  localparam logic [2:0] KIND_SET    = 3'd1;
  localparam logic [2:0] KIND_DELETE = 3'd2;
  localparam logic [2:0] KIND_LOOKUP = 3'd3;
  localparam logic [2:0] KIND_POP    = 3'd4;
  localparam logic [2:0] KIND_CLEAR  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_ZERO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_NEG = 2'd1;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] key;
    logic [63:0] amount;
  } in_t;

  typedef struct packed {
    logic [63:0]      result_value;
    logic [63:0]      result_key;
    logic             found;
    logic             table_full;
    logic [ENT_W-1:0] entry_count;
  } out_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [63:0]       key;
    logic [63:0]       amount;
    logic [SLOT_W-1:0] home;
  } req_t;

  typedef struct packed {
    logic keep_zero_counts;
    logic allow_negative;
  } cfg_t;

  // Only the low slot bits of the sum matter, so the adds and the multiply by
  // thirteen are done at slot width.
  function automatic logic [SLOT_W-1:0] home_slot(input logic [63:0] k);
    logic [15:0]       ra;
    logic [31:0]       rb;
    logic [63:0]       rc;
    logic [SLOT_W-1:0] s;
    ra = {k[8:0], k[15:9]};
    rb = {k[16:0], k[31:17]};
    rc = {k[30:0], k[63:31]};
    s  = k[SLOT_W-1:0] + ra[SLOT_W-1:0] + rb[SLOT_W-1:0] + rc[SLOT_W-1:0];
    return s + (s << 2) + (s << 3);
  endfunction

endpackage
`default_nettype wire

[rtl/keyed_counter_hash_table_top.sv]
// Top level of the keyed counter hash table: configuration and the two halves.
//
//   channel  direction  handshake            payload
//   request  in         push / full          req  (kind, key, amount)
//   result   out        pop / empty          rsp  (value, key, flags, count)
//   config   in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Lookup, add and set probe the slots of the cluster from the home slot, and
// an insertion also scans for a free slot; delete and pop add a walk of the
// following cluster for each of up to two re-hashed entries.
// Clear writes one slot index entry per cycle.
// After reset the slot index is swept before the first request is started;
// configuration writes are taken at any time.
// Up to two requests and two results are buffered, so either side may stall.
`default_nettype none
module keyed_counter_hash_table_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               push,
  output logic                                    full,
  input  wire khtab_pkg::in_t                     req,
  output logic                                    empty,
  input  wire logic                               pop,
  output khtab_pkg::out_t                         rsp,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [khtab_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic                               cfg_data
);
  import khtab_pkg::*;

  cfg_t cfg;
  logic q_empty;
  logic q_pop;
  req_t q_data;
  logic res_wr;
  logic res_full;
  out_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.keep_zero_counts <= 1'b1;
      cfg.allow_negative   <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_KEEP_ZERO: cfg.keep_zero_counts <= cfg_data;
        CFG_ALLOW_NEG: cfg.allow_negative   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  khtab_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .req     (req),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_data  (q_data)
  );

  khtab_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .q_data   (q_data),
    .res_wr   (res_wr),
    .res_full (res_full),
    .res      (res)
  );

  khtab_res_q u_res_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (res_wr),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .empty (empty),
    .rdata (rsp)
  );

endmodule
`default_nettype wire

[rtl/khtab_front.sv]
// Front end: takes requests, substitutes key zero, hashes, and queues them.
`default_nettype none
module khtab_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire khtab_pkg::in_t   req,
  output logic                  q_empty,
  input  wire logic             q_pop,
  output khtab_pkg::req_t       q_data
);
  import khtab_pkg::*;

  req_t       slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  req_t       classified;
  logic       do_push;
  logic       do_pop;

  always_comb begin
    classified.kind   = req.kind;
    classified.amount = req.amount;
    classified.key    = (req.key == 64'd0) ? ZERO_KEY_SUBST : req.key;
    classified.home   = home_slot(classified.key);
  end

  assign full    = (count == 2'd2);
  assign q_empty = (count == 2'd0);
  assign q_data  = slots[rp];
  assign do_push = push && !full;
  assign do_pop  = q_pop && !q_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wp] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wp <= ~wp;
      end
      if (do_pop) begin
        rp <= ~rp;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule
`default_nettype wire

[rtl/khtab_res_q.sv]
// Two-entry result queue between the back end and the result ports.
`default_nettype none
module khtab_res_q (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr,
  input  wire khtab_pkg::out_t  wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic                  empty,
  output khtab_pkg::out_t       rdata
);
  import khtab_pkg::*;

  out_t       slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  logic       do_wr;
  logic       do_pop;

  assign full   = (count == 2'd2);
  assign empty  = (count == 2'd0);
  assign rdata  = slots[rp];
  assign do_wr  = wr && !full;
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_wr) begin
        wp <= ~wp;
      end
      if (do_pop) begin
        rp <= ~rp;
      end
      count <= count + {1'b0, do_wr} - {1'b0, do_pop};
    end
  end

endmodule
`default_nettype wire

[rtl/khtab_back.sv]
// Back end: sequencer over the slot index and the entry memories.
`default_nettype none
module khtab_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire khtab_pkg::cfg_t  cfg,
  input  wire logic             q_empty,
  output logic                  q_pop,
  input  wire khtab_pkg::req_t  q_data,
  output logic                  res_wr,
  input  wire logic             res_full,
  output khtab_pkg::out_t       res
);
  import khtab_pkg::*;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_FIND_SLT = 5'd1;
  localparam logic [4:0] S_FIND_KEY = 5'd2;
  localparam logic [4:0] S_HIT      = 5'd3;
  localparam logic [4:0] S_MISS     = 5'd4;
  localparam logic [4:0] S_INS_SLT  = 5'd5;
  localparam logic [4:0] S_RE_START = 5'd6;
  localparam logic [4:0] S_RH_FIND  = 5'd7;
  localparam logic [4:0] S_RH_SLT   = 5'd8;
  localparam logic [4:0] S_RH_KEY   = 5'd9;
  localparam logic [4:0] S_RH_NEXT  = 5'd10;
  localparam logic [4:0] S_RE_MID   = 5'd11;
  localparam logic [4:0] S_RE_LAST  = 5'd12;
  localparam logic [4:0] S_RE_MOVE  = 5'd13;
  localparam logic [4:0] S_RE_END   = 5'd14;
  localparam logic [4:0] S_POP_RD   = 5'd15;
  localparam logic [4:0] S_CLR      = 5'd16;
  localparam logic [4:0] S_DONE     = 5'd17;

  logic [SLOT_W-1:0] slot_mem [HASH_SLOTS];
  logic [63:0]       key_mem  [ENT_DEPTH];
  logic [63:0]       cnt_mem  [ENT_DEPTH];
  logic [ENT_W-1:0]  slot_q;
  logic [63:0]       key_q;
  logic [63:0]       cnt_q;

  logic [4:0]        state, state_next;
  logic              boot, boot_next;
  logic [SLOT_W-1:0] sp, sp_next;
  logic [SLOT_W-1:0] tp, tp_next;
  logic [ENT_W-1:0]  ep, ep_next;
  logic [ENT_W-1:0]  used, used_next;
  logic [2:0]        kind, kind_next;
  logic [63:0]       k, k_next;
  logic [63:0]       v, v_next;
  logic [SLOT_W-1:0] h, h_next;
  logic [63:0]       rv, rv_next;
  logic [63:0]       rk, rk_next;
  logic              found, found_next;
  logic              tfull, tfull_next;
  logic [ENT_W-1:0]  ee, ee_next;
  logic [63:0]       ek, ek_next;
  logic [63:0]       lc, lc_next;
  logic [ENT_W-1:0]  ie, ie_next;
  logic [4:0]        ins_ret, ins_ret_next;
  logic [ENT_W-1:0]  rh_tgt, rh_tgt_next;
  logic [4:0]        rh_ret, rh_ret_next;

  logic              slot_we;
  logic [SLOT_W-1:0] slot_waddr;
  logic [ENT_W-1:0]  slot_wdata;
  logic              key_we;
  logic              cnt_we;
  logic [ENT_W-1:0]  ent_waddr;
  logic [63:0]       key_wdata;
  logic [63:0]       cnt_wdata;

  logic [63:0]       val;
  logic [SLOT_W-1:0] hk;
  logic              may_create;

  // Memories read every cycle at the address the pointers take next.
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_q <= slot_mem[sp_next];
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[ent_waddr] <= key_wdata;
    end
    if (cnt_we) begin
      cnt_mem[ent_waddr] <= cnt_wdata;
    end
    key_q <= key_mem[ep_next];
    cnt_q <= cnt_mem[ep_next];
  end

  assign val        = (kind == KIND_ADD) ? (v + cnt_q) : v;
  assign hk         = home_slot(key_q);
  assign may_create = (v != 64'd0 || cfg.keep_zero_counts) &&
                      (!v[63] || cfg.allow_negative);

  always_comb begin
    state_next   = state;
    boot_next    = boot;
    sp_next      = sp;
    tp_next      = tp;
    ep_next      = ep;
    used_next    = used;
    kind_next    = kind;
    k_next       = k;
    v_next       = v;
    h_next       = h;
    rv_next      = rv;
    rk_next      = rk;
    found_next   = found;
    tfull_next   = tfull;
    ee_next      = ee;
    ek_next      = ek;
    lc_next      = lc;
    ie_next      = ie;
    ins_ret_next = ins_ret;
    rh_tgt_next  = rh_tgt;
    rh_ret_next  = rh_ret;
    q_pop        = 1'b0;
    res_wr       = 1'b0;
    slot_we      = 1'b0;
    slot_waddr   = sp;
    slot_wdata   = '0;
    key_we       = 1'b0;
    cnt_we       = 1'b0;
    ent_waddr    = ep;
    key_wdata    = k;
    cnt_wdata    = val;

    unique case (state)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          kind_next  = q_data.kind;
          k_next     = q_data.key;
          v_next     = q_data.amount;
          h_next     = q_data.home;
          rv_next    = '0;
          rk_next    = '0;
          found_next = 1'b0;
          tfull_next = 1'b0;
          unique case (q_data.kind)
            KIND_ADD, KIND_SET, KIND_DELETE, KIND_LOOKUP: begin
              sp_next    = q_data.home;
              state_next = S_FIND_SLT;
            end
            KIND_POP: begin
              if (used != '0) begin
                found_next = 1'b1;
                ep_next    = used;
                state_next = S_POP_RD;
              end else begin
                state_next = S_DONE;
              end
            end
            KIND_CLEAR: begin
              found_next = (used != '0);
              used_next  = '0;
              sp_next    = '0;
              state_next = S_CLR;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end

      S_FIND_SLT: begin
        if (slot_q == '0) begin
          state_next = S_MISS;
        end else begin
          ep_next    = slot_q;
          state_next = S_FIND_KEY;
        end
      end

      S_FIND_KEY: begin
        if (ep <= used && key_q == k) begin
          found_next = 1'b1;
          state_next = S_HIT;
        end else begin
          sp_next    = sp + 1'b1;
          state_next = S_FIND_SLT;
        end
      end

      S_HIT: begin
        ee_next = ep;
        ek_next = key_q;
        unique case (kind)
          KIND_ADD, KIND_SET: begin
            if (val == 64'd0 && !cfg.keep_zero_counts) begin
              rv_next    = '0;
              state_next = S_RE_START;
            end else begin
              cnt_we     = 1'b1;
              rv_next    = val;
              state_next = S_DONE;
            end
          end
          KIND_DELETE: begin
            rv_next    = cnt_q;
            state_next = S_RE_START;
          end
          default: begin
            rv_next    = cnt_q;
            state_next = S_DONE;
          end
        endcase
      end

      S_MISS: begin
        if ((kind == KIND_ADD || kind == KIND_SET) && may_create) begin
          if (used >= ENT_W'(MAX_ENTRIES)) begin
            tfull_next = 1'b1;
            state_next = S_DONE;
          end else begin
            used_next    = used + 1'b1;
            ent_waddr    = used + 1'b1;
            key_we       = 1'b1;
            cnt_we       = 1'b1;
            cnt_wdata    = v;
            rv_next      = v;
            ie_next      = used + 1'b1;
            sp_next      = h;
            ins_ret_next = S_DONE;
            state_next   = S_INS_SLT;
          end
        end else begin
          state_next = S_DONE;
        end
      end

      S_INS_SLT: begin
        if (slot_q == '0) begin
          slot_we    = 1'b1;
          slot_wdata = ie;
          state_next = ins_ret;
        end else begin
          sp_next = sp + 1'b1;
        end
      end

      S_RE_START: begin
        rh_tgt_next = ee;
        sp_next     = home_slot(ek);
        rh_ret_next = S_RE_MID;
        state_next  = S_RH_FIND;
      end

      S_RH_FIND: begin
        sp_next = sp + 1'b1;
        if (slot_q == rh_tgt) begin
          slot_we    = 1'b1;
          tp_next    = sp + 1'b1;
          state_next = S_RH_SLT;
        end
      end

      S_RH_SLT: begin
        if (slot_q == '0) begin
          state_next = rh_ret;
        end else begin
          ep_next    = slot_q;
          ie_next    = slot_q;
          state_next = S_RH_KEY;
        end
      end

      S_RH_KEY: begin
        if (hk == sp) begin
          sp_next    = sp + 1'b1;
          tp_next    = sp + 1'b1;
          state_next = S_RH_SLT;
        end else begin
          // Pull the entry out and put it back from its home slot.
          slot_we      = 1'b1;
          tp_next      = sp;
          sp_next      = hk;
          ins_ret_next = S_RH_NEXT;
          state_next   = S_INS_SLT;
        end
      end

      S_RH_NEXT: begin
        sp_next    = tp + 1'b1;
        tp_next    = tp + 1'b1;
        state_next = S_RH_SLT;
      end

      S_RE_MID: begin
        if (ee < used) begin
          ep_next    = used;
          state_next = S_RE_LAST;
        end else begin
          state_next = S_RE_END;
        end
      end

      S_RE_LAST: begin
        ek_next     = key_q;
        lc_next     = cnt_q;
        rh_tgt_next = used;
        sp_next     = hk;
        rh_ret_next = S_RE_MOVE;
        state_next  = S_RH_FIND;
      end

      S_RE_MOVE: begin
        // The last entry fills the hole so the entry array stays dense.
        ent_waddr    = ee;
        key_we       = 1'b1;
        cnt_we       = 1'b1;
        key_wdata    = ek;
        cnt_wdata    = lc;
        ie_next      = ee;
        sp_next      = home_slot(ek);
        ins_ret_next = S_RE_END;
        state_next   = S_INS_SLT;
      end

      S_RE_END: begin
        used_next  = used - 1'b1;
        state_next = S_DONE;
      end

      S_POP_RD: begin
        rv_next    = cnt_q;
        rk_next    = key_q;
        ee_next    = ep;
        ek_next    = key_q;
        state_next = S_RE_START;
      end

      S_CLR: begin
        slot_we = 1'b1;
        sp_next = sp + 1'b1;
        if (sp == SLOT_W'(HASH_SLOTS - 1)) begin
          boot_next  = 1'b0;
          state_next = boot ? S_IDLE : S_DONE;
        end
      end

      S_DONE: begin
        if (!res_full) begin
          res_wr     = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign res.result_value = rv;
  assign res.result_key   = rk;
  assign res.found        = found;
  assign res.table_full   = tfull;
  assign res.entry_count  = used;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      boot  <= 1'b1;
      sp    <= '0;
      used  <= '0;
    end else begin
      state <= state_next;
      boot  <= boot_next;
      sp    <= sp_next;
      used  <= used_next;
    end
  end

  always_ff @(posedge clk) begin
    tp      <= tp_next;
    ep      <= ep_next;
    kind    <= kind_next;
    k       <= k_next;
    v       <= v_next;
    h       <= h_next;
    rv      <= rv_next;
    rk      <= rk_next;
    found   <= found_next;
    tfull   <= tfull_next;
    ee      <= ee_next;
    ek      <= ek_next;
    lc      <= lc_next;
    ie      <= ie_next;
    ins_ret <= ins_ret_next;
    rh_tgt  <= rh_tgt_next;
    rh_ret  <= rh_ret_next;
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= ENT_W'(MAX_ENTRIES))
    else $error("entry count above capacity");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !slot_we && !key_we && !cnt_we)
    else $error("memory write while idle");

  a_used_step: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && used != $past(used) |->
      used == $past(used) + 1'b1 || used == $past(used) - 1'b1 || used == '0)
    else $error("entry count jumped");

  a_result_in_done: assert property (@(posedge clk) disable iff (rst)
    res_wr |-> state == S_DONE && !res_full)
    else $error("result written outside completion");

endmodule
`default_nettype wire
